// ----- rtl/intel_hex_page_loader_assert.svh -----
// Assertion macros for the page loader RTL.
`ifndef INTEL_HEX_PAGE_LOADER_ASSERT_SVH
`define INTEL_HEX_PAGE_LOADER_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define IHPL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define IHPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ihpl_pkg.sv -----
// Shared constants and types for the Intel HEX page loader.
package ihpl_pkg;

  localparam int PAGE_BYTES    = 128;
  localparam int ADDR_BITS     = 17;
  localparam int OFFSET_BITS   = (PAGE_BYTES > 2) ? $clog2(PAGE_BYTES) : 1;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam logic KIND_DATA        = 1'b0;
  localparam logic KIND_FINISH      = 1'b1;
  localparam logic CAUSE_END_RECORD = 1'b0;
  localparam logic CAUSE_FILE_END   = 1'b1;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [4:0] NIB_MASK   = 5'h1f;
  localparam logic [4:0] NIB_DIGIT  = 5'h10;
  localparam logic [4:0] NIB_TEN    = 5'h0a;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           data_byte;
    logic [ADDR_BITS-1:0] byte_address;
    logic                 page_full;
    logic                 flush_partial;
    logic                 finish_cause;
    logic                 last_result;
  } result_t;

  // Up to two results leave the parser per character.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ----- rtl/ihpl_parser.sv -----
// Record parser: phase machine, hex decoding and flash address tracking.
module ihpl_parser
  import ihpl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_char,
  input  logic       file_end,
  input  logic       type_mode,
  output push_t      push
);

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_CNT_HI,
    PH_CNT_LO,
    PH_ADDR,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_DATA_HI,
    PH_DATA_LO
  } phase_t;

  phase_t                 phase, phase_next;
  logic [4:0]             high_nibble, high_nibble_next;
  logic [7:0]             bytes_left, bytes_left_next;
  logic [1:0]             skip_count, skip_count_next;
  logic [OFFSET_BITS-1:0] page_offset, page_offset_next;
  logic [ADDR_BITS-1:0]   page_base, page_base_next;
  logic                   finished;

  logic [4:0]             nib;
  logic [7:0]             joined;
  logic [OFFSET_BITS:0]   offset_inc;
  logic                   end_rec;
  logic                   emit_data;
  logic                   full;
  logic                   fin;
  result_t                data_res, finish_res;

  function automatic logic [4:0] hex_nib(input logic [7:0] c);
    logic [4:0] a;
    a = c[4:0] & NIB_MASK;
    if (a >= NIB_DIGIT) begin
      return a - NIB_DIGIT;
    end
    return a + NIB_TEN - 5'd1;
  endfunction

  always_comb begin
    nib        = hex_nib(in_char);
    joined     = {high_nibble[3:0], 4'b0000} + {3'b000, nib};
    offset_inc = {1'b0, page_offset} + {{OFFSET_BITS{1'b0}}, 1'b1};

    phase_next       = phase;
    high_nibble_next = high_nibble;
    bytes_left_next  = bytes_left;
    skip_count_next  = skip_count;
    page_offset_next = page_offset;
    page_base_next   = page_base;
    end_rec          = 1'b0;
    emit_data        = 1'b0;
    full             = 1'b0;

    case (phase)
      PH_CNT_HI, PH_TYPE_HI, PH_DATA_HI: begin
        high_nibble_next = nib;
        phase_next       = phase_t'(phase + 3'd1);
      end
      PH_CNT_LO: begin
        bytes_left_next = joined;
        skip_count_next = 2'd0;
        phase_next      = PH_ADDR;
      end
      PH_ADDR: begin
        if (skip_count == 2'd3) begin
          skip_count_next = 2'd0;
          phase_next      = PH_TYPE_HI;
        end else begin
          skip_count_next = skip_count + 2'd1;
        end
      end
      PH_TYPE_LO: begin
        if (joined != 8'd0) begin
          if (!type_mode || joined == 8'd1) begin
            end_rec = 1'b1;
          end else begin
            bytes_left_next = 8'd0;
          end
        end
        phase_next = (bytes_left_next != 8'd0) ? PH_DATA_HI : PH_WAIT;
      end
      PH_DATA_LO: begin
        emit_data = 1'b1;
        if (offset_inc >= (OFFSET_BITS+1)'(PAGE_BYTES)) begin
          full             = 1'b1;
          page_offset_next = '0;
          page_base_next   = page_base + ADDR_BITS'(PAGE_BYTES);
        end else begin
          page_offset_next = offset_inc[OFFSET_BITS-1:0];
        end
        bytes_left_next = bytes_left - 8'd1;
        phase_next      = (bytes_left_next != 8'd0) ? PH_DATA_HI : PH_WAIT;
      end
      default: begin
        phase_next = (in_char == CHAR_COLON) ? PH_CNT_HI : PH_WAIT;
      end
    endcase

    fin = end_rec || file_end;

    data_res.kind          = KIND_DATA;
    data_res.data_byte     = joined;
    data_res.byte_address  = page_base + ADDR_BITS'(page_offset);
    data_res.page_full     = full;
    data_res.flush_partial = 1'b0;
    data_res.finish_cause  = CAUSE_END_RECORD;
    data_res.last_result   = !fin;

    finish_res.kind          = KIND_FINISH;
    finish_res.data_byte     = 8'd0;
    finish_res.byte_address  = page_base_next;
    finish_res.page_full     = 1'b0;
    finish_res.flush_partial = (page_offset_next != '0);
    finish_res.finish_cause  = end_rec ? CAUSE_END_RECORD : CAUSE_FILE_END;
    finish_res.last_result   = 1'b1;

    push.first  = data_res;
    push.second = finish_res;
    push.count  = 2'd0;
    if (step && !finished) begin
      if (emit_data && fin) begin
        push.count = 2'd2;
      end else if (emit_data) begin
        push.count = 2'd1;
      end else if (fin) begin
        push.count = 2'd1;
        push.first = finish_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      high_nibble <= '0;
      bytes_left  <= '0;
      skip_count  <= '0;
      page_offset <= '0;
      page_base   <= '0;
      finished    <= 1'b0;
    end else if (step && !finished) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      bytes_left  <= bytes_left_next;
      skip_count  <= skip_count_next;
      page_offset <= page_offset_next;
      page_base   <= page_base_next;
      finished    <= fin;
    end
  end

endmodule

// ----- rtl/ihpl_result_fifo.sv -----
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
`include "intel_hex_page_loader_assert.svh"

module ihpl_result_fifo
  import ihpl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_PTR_BITS:0]   count;
  logic                     pop;

  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Keep space for a data word and a finish word together.
  assign room      = (count <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + FIFO_PTR_BITS'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      count <= count + (FIFO_PTR_BITS+1)'(push.count) - (FIFO_PTR_BITS+1)'(pop);
    end
  end

  `IHPL_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= (FIFO_PTR_BITS+1)'(FIFO_DEPTH), "result queue overfilled")
  `IHPL_ASSERT_IMPLY(a_push_room, clk, rst, push.count != 2'd0, room, "result pushed without room")
  `IHPL_ASSERT_IMPLY(a_pair_order, clk, rst, push.count == 2'd2, push.second.kind == KIND_FINISH && push.first.kind == KIND_DATA && !push.first.last_result, "bad result pair")
  `IHPL_ASSERT_NEXT(a_push_shows, clk, rst, push.count != 2'd0, out_valid, "pushed result not offered")

endmodule

// ----- rtl/intel_hex_page_loader.sv -----
// Intel HEX page loader top level: input register, mode register, parser and result queue.
//
// Accepts one file character per clock cycle and returns decoded data words, each with its
// flash address and a page-full flag, followed by one finish word at an end record or at the
// character marked file_end. A character is registered on acceptance and parsed once the
// queue has room; its results are written to a four-entry queue, and results leave it at one
// per cycle while out_ready is high. Input stalls only while the queue holds more than two
// words, since a character can cause a data word and a finish word together. After the
// finish word the block takes characters and drops them until reset.
// type_mode is written through the cfg channel, which is always ready.
module intel_hex_page_loader
  import ihpl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_char,
  input  logic                 file_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 type_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 kind,
  output logic [7:0]           data_byte,
  output logic [ADDR_BITS-1:0] byte_address,
  output logic                 page_full,
  output logic                 flush_partial,
  output logic                 finish_cause,
  output logic                 last_result
);

  logic       in_full;
  logic [7:0] char_q;
  logic       file_end_q;
  logic       mode;
  logic       room;
  logic       step;
  push_t      push;
  result_t    out_res;

  assign step      = in_full && room;
  assign in_ready  = !in_full || step;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q     <= in_char;
      file_end_q <= file_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid) begin
      mode <= type_mode;
    end
  end

  ihpl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .in_char   (char_q),
    .file_end  (file_end_q),
    .type_mode (mode),
    .push      (push)
  );

  ihpl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind          = out_res.kind;
  assign data_byte     = out_res.data_byte;
  assign byte_address  = out_res.byte_address;
  assign page_full     = out_res.page_full;
  assign flush_partial = out_res.flush_partial;
  assign finish_cause  = out_res.finish_cause;
  assign last_result   = out_res.last_result;

endmodule
